[rtl/ncs_pkg.sv]
// Shared constants and types for the nearest center search unit.
package ncs_pkg;

  localparam int MAX_CANDIDATES = 4096;
  localparam int COORD_W        = 24;
  localparam int BOUND_W        = 52;
  localparam int INDEX_W        = 12;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  // Magnitude of a coordinate difference fits in COORD_W + 1 bits.
  localparam int MAG_W          = COORD_W + 1;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int DIST_W         = SQ_W + 2;
  localparam int CMP_W          = (DIST_W > BOUND_W) ? DIST_W : BOUND_W;
  localparam int CFG_DATA_W     = BOUND_W;

  typedef enum logic [1:0] {
    CFG_QUERY_X     = 2'd0,
    CFG_QUERY_Y     = 2'd1,
    CFG_QUERY_Z     = 2'd2,
    CFG_START_BOUND = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_y;
    logic [COORD_W-1:0] query_z;
    logic [BOUND_W-1:0] start_bound_sq;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
  } dist_item_t;

endpackage

[rtl/ncs_in_if.sv]
// Candidate center channel: valid/ready handshake with coordinate payload.
interface ncs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ncs_pkg::COORD_W-1:0] center_x;
  logic [ncs_pkg::COORD_W-1:0] center_y;
  logic [ncs_pkg::COORD_W-1:0] center_z;
  logic                        last_item;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output last_item, input ready);
  modport sink   (input valid, input center_x, input center_y, input center_z,
                  input last_item, output ready);
endinterface

[rtl/ncs_out_if.sv]
// Search result channel: valid/ready handshake with found, index and overflow.
interface ncs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [ncs_pkg::INDEX_W-1:0] best_index;
  logic                        overflow;

  modport source (output valid, output found, output best_index, output overflow,
                  input ready);
  modport sink   (input valid, input found, input best_index, input overflow,
                  output ready);
endinterface

[rtl/ncs_cfg_regs.sv]
// Configuration registers: query point and starting squared bound.
module ncs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  ncs_pkg::cfg_idx_t            cfg_index,
  input  logic [ncs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ncs_pkg::cfg_t                cfg
);
  import ncs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_X:     cfg_nxt.query_x        = cfg_wdata[COORD_W-1:0];
        CFG_QUERY_Y:     cfg_nxt.query_y        = cfg_wdata[COORD_W-1:0];
        CFG_QUERY_Z:     cfg_nxt.query_z        = cfg_wdata[COORD_W-1:0];
        CFG_START_BOUND: cfg_nxt.start_bound_sq = cfg_wdata[BOUND_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

[rtl/ncs_dist_pipe.sv]
// Input register and per-axis squared difference stage.
module ncs_dist_pipe (
  input  logic                clk,
  input  logic                rst_n,
  ncs_in_if.sink              in_ch,
  input  ncs_pkg::cfg_t       cfg,
  input  logic                take,
  output ncs_pkg::dist_item_t item
);
  import ncs_pkg::*;

  logic               a_valid_r, a_valid_nxt;
  logic               a_last_r;
  logic [COORD_W-1:0] a_x_r, a_y_r, a_z_r;
  dist_item_t         b_r, b_nxt;
  logic               b_load;
  logic               a_load;
  logic [MAG_W-1:0]   mag_x, mag_y, mag_z;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] q);
    logic [MAG_W-1:0] d;
    d = {c[COORD_W-1], c} - {q[COORD_W-1], q};
    return d[MAG_W-1] ? MAG_W'(-d) : d;
  endfunction

  // The square stage frees up when empty or when the tracker takes its word.
  assign b_load = !b_r.valid || take;
  assign a_load = !a_valid_r || b_load;
  assign in_ch.ready = a_load;

  assign mag_x = abs_diff(a_x_r, cfg.query_x);
  assign mag_y = abs_diff(a_y_r, cfg.query_y);
  assign mag_z = abs_diff(a_z_r, cfg.query_z);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = in_ch.valid;
    end
    b_nxt = b_r;
    if (b_load) begin
      b_nxt.valid = a_valid_r;
      b_nxt.last  = a_last_r;
      b_nxt.sq_x  = SQ_W'(mag_x) * SQ_W'(mag_x);
      b_nxt.sq_y  = SQ_W'(mag_y) * SQ_W'(mag_y);
      b_nxt.sq_z  = SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_r       <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_r       <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_x_r    <= in_ch.center_x;
      a_y_r    <= in_ch.center_y;
      a_z_r    <= in_ch.center_z;
      a_last_r <= in_ch.last_item;
    end
  end

  assign item = b_r;
endmodule

[rtl/ncs_min_track.sv]
// Distance sum, running minimum compare, search state and result register.
module ncs_min_track (
  input  logic                clk,
  input  logic                rst_n,
  input  ncs_pkg::dist_item_t item,
  input  ncs_pkg::cfg_t       cfg,
  output logic                take,
  ncs_out_if.source           out_ch
);
  import ncs_pkg::*;

  logic [BOUND_W-1:0] min_r, min_nxt;
  logic [INDEX_W-1:0] best_r, best_nxt;
  logic               have_r, have_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic [DIST_W-1:0]  dist_sum;
  logic [BOUND_W-1:0] min_eff;
  logic               closer;

  // A non-final word never needs the result register, so it passes a stall.
  assign take = item.valid && (!item.last || !out_valid_r || out_ch.ready);

  assign dist_sum = DIST_W'(item.sq_x) + DIST_W'(item.sq_y) + DIST_W'(item.sq_z);
  assign min_eff  = (count_r == '0) ? cfg.start_bound_sq : min_r;
  assign closer   = CMP_W'(dist_sum) < CMP_W'(min_eff);

  always_comb begin
    min_nxt       = min_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (take) begin
      min_nxt = min_eff;
      if (count_r < CNT_W'(MAX_CANDIDATES)) begin
        if (closer) begin
          min_nxt  = BOUND_W'(dist_sum);
          best_nxt = INDEX_W'(count_r);
          have_nxt = 1'b1;
        end
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (item.last) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = have_nxt;
        out_index_nxt = have_nxt ? best_nxt : '0;
        out_ovf_nxt   = ovf_nxt;
        best_nxt      = '0;
        have_nxt      = 1'b0;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      best_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      best_r      <= best_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r       <= min_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.best_index = out_index_r;
  assign out_ch.overflow   = out_ovf_r;
endmodule

[rtl/nearest_center_search_unit.sv]
// Top level of the nearest center search unit.
//
// Candidate centers (signed Q12.12 x, y, z) arrive on in_ch as words with a
// valid/ready handshake; last_item marks the final candidate of a search.
// The query point and the starting squared bound are set through the write
// port cfg_we/cfg_index/cfg_wdata; the user must write them only while no
// search is in flight, not enforced by the block. Each word is registered,
// its three per-axis squared differences are formed and registered, then
// the sum is compared against the running minimum. A strictly smaller
// distance takes the candidate's position as best. One word is accepted per
// cycle while in_ch.ready is high, as the running minimum compare loop is
// combinational. The final word of a search yields one registered result
// word on out_ch (found, best_index, overflow); other words give no result.
// The search state then restarts for the next stream. When the receiver
// stalls, non-final words keep flowing; only a final word waits behind a
// pending result, and in_ch.ready drops once the stages fill. Reset clears
// the configuration registers, the search state and all stage valid flags.
module nearest_center_search_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ncs_in_if.sink                         in_ch,
  ncs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  ncs_pkg::cfg_idx_t              cfg_index,
  input  logic [ncs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ncs_pkg::*;

  cfg_t       cfg;
  dist_item_t item;
  logic       take;

  ncs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ncs_dist_pipe u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .take  (take),
    .item  (item)
  );

  ncs_min_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .cfg    (cfg),
    .take   (take),
    .out_ch (out_ch)
  );
endmodule
